### design/fer_pkg.sv
// Package for the binary64 exact remainder core: field widths, constants.
// No dependencies.
package fer_pkg;
   localparam int WordWidth = 64;
   localparam int FracBits = 52;
   localparam int ExpWidth = 11;
   localparam int SigWidth = 54;
   localparam logic [ExpWidth-1:0] ExpMax = 11'h7FF;
   localparam logic [63:0] AbsMask = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] InfBits = 64'h7FF0_0000_0000_0000;

   typedef struct packed {
      logic [63:0] dividend_bits;
      logic [63:0] divisor_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] remainder_bits;
      logic invalid;
   } rsp_type;
endpackage

### design/fer_if.sv
// Valid/ready channel interface carrying a payload of a given type.
// No dependencies; the payload type is a parameter.
interface fer_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/fer_datapath.sv
// Shared shift/subtract unit: one conditional subtract per step, then a shift when do_shift is set.
// Depends on fer_pkg.
module fer_datapath (
   input  logic [fer_pkg::SigWidth-1:0] mx,
   input  logic [fer_pkg::SigWidth-1:0] my,
   input  logic                         do_shift,
   output logic [fer_pkg::SigWidth-1:0] mx_next
);
   import fer_pkg::*;
   logic [SigWidth-1:0] diff;
   always_comb begin
      diff = (mx >= my) ? (mx - my) : mx;
      mx_next = do_shift ? {diff[SigWidth-2:0], 1'b0} : diff;
   end
endmodule

### design/float_exact_remainder_core.sv
// Binary64 fmod core, top level; depends on fer_pkg, fer_if, fer_datapath.
// Steps: normalize subnormal operands, shift/subtract over the exponent gap, a last subtract,
// then normalize the result; invalid and small-dividend items go straight to the result.
// Throughput: one item at a time; ready low while busy or while a result waits,
// back high the cycle after the result transfer.
// Synchronous active-high reset returns the sequencer to idle, no result pending.
module float_exact_remainder_core (
   input logic clock,
   input logic reset,
   fer_if.sink   req,
   fer_if.source rsp
);
   import fer_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_NORMX, S_NORMY, S_LOOP, S_LAST, S_NORM, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [SigWidth-1:0] mx_ff, mx_in, my_ff, my_in;
   logic signed [12:0] ex_ff, ex_in, ey_ff, ey_in;
   logic sx_ff, sx_in;
   logic [63:0] res_ff, res_in;
   logic inv_ff, inv_in;
   logic [SigWidth-1:0] dp_out;
   logic dp_shift;
   logic [63:0] ax, ay;
   logic [63:0] sub_m;
   logic [12:0] sh;

   fer_datapath u_dp (.mx(mx_ff), .my(my_ff), .do_shift(dp_shift), .mx_next(dp_out));

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_DONE);
   assign rsp.data.remainder_bits = res_ff;
   assign rsp.data.invalid = inv_ff;
   assign ax = req.data.dividend_bits & AbsMask;
   assign ay = req.data.divisor_bits & AbsMask;
   assign dp_shift = (state_ff == S_LOOP);

   always_comb begin
      state_in = state_ff;
      mx_in = mx_ff; my_in = my_ff; ex_in = ex_ff; ey_in = ey_ff;
      sx_in = sx_ff; res_in = res_ff; inv_in = inv_ff;
      sh = 13'(1 - ex_ff);
      sub_m = (sh < 13'd64) ? (64'(mx_ff) >> sh[5:0]) : 64'd0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               sx_in = req.data.dividend_bits[63];
               res_in = req.data.dividend_bits;
               inv_in = 1'b0;
               mx_in = {1'b0, (ax[62:52] != 0), ax[51:0]};
               my_in = {1'b0, (ay[62:52] != 0), ay[51:0]};
               ex_in = (ax[62:52] == 0) ? 13'sd1 : 13'(ax[62:52]);
               ey_in = (ay[62:52] == 0) ? 13'sd1 : 13'(ay[62:52]);
               if (ax >= InfBits || ay > InfBits || ay == 64'd0) begin
                  res_in = QnanBits; inv_in = 1'b1; state_in = S_DONE;
               end else if (ax < ay) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_NORMX;
               end
            end
         end
         S_NORMX: begin
            if (!mx_ff[FracBits]) begin
               mx_in = {mx_ff[SigWidth-2:0], 1'b0}; ex_in = ex_ff - 13'sd1;
            end else state_in = S_NORMY;
         end
         S_NORMY: begin
            if (!my_ff[FracBits]) begin
               my_in = {my_ff[SigWidth-2:0], 1'b0}; ey_in = ey_ff - 13'sd1;
            end else state_in = (ex_ff > ey_ff) ? S_LOOP : S_LAST;
         end
         S_LOOP: begin
            mx_in = dp_out; ex_in = ex_ff - 13'sd1;
            if (ex_ff - 13'sd1 <= ey_ff) state_in = S_LAST;
         end
         S_LAST: begin
            mx_in = dp_out;
            if (dp_out == 0) begin
               res_in = {sx_ff, 63'd0}; state_in = S_DONE;
            end else state_in = S_NORM;
         end
         S_NORM: begin
            if (!mx_ff[FracBits]) begin
               mx_in = {mx_ff[SigWidth-2:0], 1'b0}; ex_in = ex_ff - 13'sd1;
            end else begin
               if (ex_ff >= 13'sd1)
                  res_in = {sx_ff, ex_ff[10:0], mx_ff[51:0]};
               else
                  res_in = {sx_ff, 11'd0, sub_m[51:0]};
               state_in = S_DONE;
            end
         end
         S_DONE: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      mx_ff <= mx_in; my_ff <= my_in; ex_ff <= ex_in; ey_ff <= ey_in;
      sx_ff <= sx_in; res_ff <= res_in; inv_ff <= inv_in;
   end

   // result held stable while waiting for transfer
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data.remainder_bits))
      else $error("result changed while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready while result pending");
   a_nan: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.invalid |-> rsp.data.remainder_bits == QnanBits)
      else $error("invalid without qnan");
endmodule

### test/tb_fmod_scoreboard.sv
// Scoreboard for the binary64 fmod core: predicts remainders, checks responses.
// Depends on fer_pkg for payload types.
package tb_fmod_scoreboard_pkg;
   import fer_pkg::*;

   class fmod_scoreboard;
      rsp_type pending_rems[$];
      int errors;
      int checked;

      function new();
         errors = 0;
         checked = 0;
      endfunction

      // unpack finite nonzero magnitude; exponent may go below 1 for subnormals
      static function void split(input logic [63:0] mag, output logic [63:0] sig,
                                 output int ex);
         logic [63:0] m;
         int e;
         e = int'(mag[62:52]);
         m = {12'h0, mag[51:0]};
         if (e == 0) begin
            e = 1;
            while (m[52] == 1'b0 && m != 0) begin
               m = m << 1;
               e--;
            end
         end else begin
            m[52] = 1'b1;
         end
         sig = m;
         ex = e;
      endfunction

      static function rsp_type predict_rem(input req_type r);
         rsp_type o;
         logic [63:0] ax, ay, mx, my, sx, m;
         int ex, ey, sh;
         sx = r.dividend_bits & 64'h8000_0000_0000_0000;
         ax = r.dividend_bits & AbsMask;
         ay = r.divisor_bits & AbsMask;
         o.invalid = 1'b0;
         if (ax >= InfBits || ay > InfBits || ay == 0) begin
            o.remainder_bits = QnanBits;
            o.invalid = 1'b1;
            return o;
         end
         if (ax < ay) begin
            o.remainder_bits = r.dividend_bits;
            return o;
         end
         split(ax, mx, ex);
         split(ay, my, ey);
         for (; ex > ey; ex--) begin
            if (mx >= my) mx = mx - my;
            mx = mx << 1;
         end
         if (mx >= my) mx = mx - my;
         if (mx == 0) begin
            o.remainder_bits = sx;
            return o;
         end
         while (mx[52] == 1'b0) begin
            mx = mx << 1;
            ex--;
         end
         if (ex >= 1) begin
            o.remainder_bits = sx | (64'(ex) << FracBits) | {12'h0, mx[51:0]};
         end else begin
            sh = 1 - ex;
            m = (sh < 64) ? (mx >> sh) : 64'h0;
            o.remainder_bits = sx | {12'h0, m[51:0]};
         end
         return o;
      endfunction

      function void note_operands(input req_type r);
         pending_rems.push_back(predict_rem(r));
      endfunction

      function void check_rem(input rsp_type got);
         rsp_type want;
         checked++;
         if (pending_rems.size() == 0) begin
            $display("%0t: unexpected response rem=%h inv=%b", $time,
                     got.remainder_bits, got.invalid);
            errors++;
            return;
         end
         want = pending_rems.pop_front();
         if (got.remainder_bits !== want.remainder_bits) begin
            $display("%0t: remainder mismatch expected %h actual %h", $time,
                     want.remainder_bits, got.remainder_bits);
            errors++;
         end
         if (got.invalid !== want.invalid) begin
            $display("%0t: invalid mismatch expected %b actual %b", $time,
                     want.invalid, got.invalid);
            errors++;
         end
      endfunction
   endclass
endpackage

### test/tb_float_exact_remainder_core.sv
// Testbench top for float_exact_remainder_core: directed and random binary64 fmod.
// Depends on fer_pkg, fer_if, tb_fmod_scoreboard_pkg and the core RTL.
module tb_float_exact_remainder_core;
   timeunit 1ns;
   timeprecision 1ps;
   import fer_pkg::*;
   import tb_fmod_scoreboard_pkg::*;

   localparam int WatchdogLimit = 60000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int stall_count = 0;
   int sent = 0;
   bit sending_done = 1'b0;
   fmod_scoreboard board = new();

   fer_if #(.payload_type(req_type)) req ();
   fer_if #(.payload_type(rsp_type)) rsp ();

   float_exact_remainder_core u_top (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #4 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   // monitor: note transfers at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) board.note_operands(req.data);
         if (rsp.valid && rsp.ready) board.check_rem(rsp.data);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_count <= 0;
         else stall_count <= stall_count + 1;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (stall_count >= WatchdogLimit) begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, WatchdogLimit);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // random binary64 with classes weighted toward interesting values
   function automatic logic [63:0] rand_float(input int near_exp);
      logic [63:0] w;
      int pick;
      w = rand_word();
      pick = $urandom_range(99);
      if (pick < 5) w[62:0] = 63'h0;
      else if (pick < 10) w[62:52] = 11'h7FF;
      else if (pick < 20) w[62:52] = 11'h000;
      else if (pick < 40) w[62:52] = 11'(near_exp + $urandom_range(60) - 30);
      else if (pick < 75) w[62:52] = 11'(near_exp + $urandom_range(8) - 4);
      else if (pick < 80) w[51:0] = 52'h0;
      return w;
   endfunction

   // valid stays high after a transfer until the next item or an idle cycle;
   // the core drops ready after each transfer, so nothing is taken twice
   task automatic send(input logic [63:0] a, input logic [63:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.data <= '{dividend_bits: a, divisor_bits: b};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic run_random(input int count);
      int e;
      repeat (count) begin
         e = $urandom_range(2046);
         send(rand_float(e), rand_float(($urandom_range(3) == 0) ? $urandom_range(2046) : e));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // directed: extremes, invalid operands, small dividend, exact multiple, subnormals
      send(64'h4014_0000_0000_0000, 64'h4008_0000_0000_0000); // 5 % 3
      send(64'hC014_0000_0000_0000, 64'h4008_0000_0000_0000); // -5 % 3
      send(64'hC018_0000_0000_0000, 64'h4008_0000_0000_0000); // -6 % 3 -> -0
      send(64'h7FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000); // qNaN dividend
      send(64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0001); // sNaN divisor
      send(64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000); // -inf dividend
      send(64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0000); // zero divisor
      send(64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000); // -0 divisor
      send(64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000); // -0 dividend
      send(64'hBFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000); // inf divisor
      send(64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000); // small dividend
      send(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001); // widest exponent gap
      send(64'h7FEF_FFFF_FFFF_FFFF, 64'h000F_FFFF_FFFF_FFFF);
      send(64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0003); // subnormal both
      send(64'h0010_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF);
      send(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF); // equal
      send(64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001);
      send(64'h0020_0000_0000_0001, 64'h0010_0000_0000_0003); // subnormal result
      send(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send(64'h4340_0000_0000_0001, 64'hC000_0000_0000_0000);
      req_idle_pct = 0;   rsp_stall_pct = 0;  run_random(70);
      req_idle_pct = 57;  rsp_stall_pct = 0;  run_random(65);
      req_idle_pct = 0;   rsp_stall_pct = 57; run_random(65);
      req_idle_pct = 11;  rsp_stall_pct = 11; run_random(60);
      req.valid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      wait (sending_done);
      while (board.pending_rems.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d operand pairs, %0d responses checked, under four",
               sent, board.checked);
      $display("idle/stall mixes including NaN, inf, zero and subnormal operands.");
      if (board.errors == 0 && board.pending_rems.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
